// File: hw/rtl/sdspi_pkg.sv
// sdspi_pkg: codes, phase and step types, and helper functions for the sd card spi host engine
// no dependencies; imported by sd_card_spi_host_engine
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int CNT_W = 10;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_CARD    = 2'd1,
    KIND_WRITE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_TYPE  = 3'd3,
    OP_COUNT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_ERROR     = 2'd1,
    RES_NOT_READY = 2'd2,
    RES_PARAM     = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    AW_NONE = 2'd0,
    AW_CARD = 2'd1,
    AW_HOST = 2'd2
  } await_t;

  typedef enum logic [2:0] {
    SUB_NONE  = 3'd0,
    SUB_DUMMY = 3'd1,
    SUB_CMD   = 3'd2,
    SUB_RECV4 = 3'd3,
    SUB_RX    = 3'd4,
    SUB_TX    = 3'd5
  } sub_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_DUMMY  = 3'd1,
    ACT_CMD    = 3'd2,
    ACT_RECV4  = 3'd3,
    ACT_RX     = 3'd4,
    ACT_TX     = 3'd5,
    ACT_FINISH = 3'd6
  } act_t;

  typedef enum logic [5:0] {
    PH_IDLE              = 6'd0,
    PH_INIT_START        = 6'd1,
    PH_INIT_GO_IDLE      = 6'd2,
    PH_INIT_GO_IDLE_RESP = 6'd3,
    PH_INIT_IF_COND      = 6'd4,
    PH_INIT_IF_COND_RESP = 6'd5,
    PH_INIT_OCR_CHECK    = 6'd6,
    PH_INIT_SD2_ACMD41   = 6'd7,
    PH_INIT_SD2_PAUSE    = 6'd8,
    PH_INIT_SD2_CMD58    = 6'd9,
    PH_INIT_SD2_CCS      = 6'd10,
    PH_INIT_V1_PROBE     = 6'd11,
    PH_INIT_V1_PAUSE     = 6'd12,
    PH_INIT_V1_LOOP      = 6'd13,
    PH_INIT_V1_PAUSE2    = 6'd14,
    PH_INIT_V1_BLKLEN    = 6'd15,
    PH_INIT_SET_TYPE     = 6'd16,
    PH_INIT_FINISH       = 6'd17,
    PH_RD_START          = 6'd20,
    PH_RD_SINGLE         = 6'd21,
    PH_RD_SINGLE_DATA    = 6'd22,
    PH_RD_MULTI          = 6'd23,
    PH_RD_MULTI_DATA     = 6'd24,
    PH_RD_CLOSE          = 6'd25,
    PH_RD_FINISH         = 6'd26,
    PH_WR_START          = 6'd30,
    PH_WR_SINGLE         = 6'd31,
    PH_WR_SINGLE_DATA    = 6'd32,
    PH_WR_MULTI_CMD      = 6'd33,
    PH_WR_MULTI          = 6'd34,
    PH_WR_MULTI_DATA     = 6'd35,
    PH_WR_FINISH         = 6'd36,
    PH_WR_STOP           = 6'd37,
    PH_CNT_START         = 6'd40,
    PH_CNT_CSD           = 6'd41,
    PH_CNT_CSD_DATA      = 6'd42,
    PH_CNT_CLOSE         = 6'd43,
    PH_CNT_FINISH        = 6'd44,
    PH_TYPE_START        = 6'd50,
    PH_TYPE_FINISH       = 6'd51
  } phase_t;

  // stage codes, meaning depends on the sub-sequence
  localparam logic [2:0] STG_LEAD     = 3'd0;
  localparam logic [2:0] STG_FRAME    = 3'd1;
  localparam logic [2:0] STG_GAP      = 3'd2;
  localparam logic [2:0] STG_RX_TOKEN = 3'd0;
  localparam logic [2:0] STG_RX_DATA  = 3'd1;
  localparam logic [2:0] STG_RX_CRC   = 3'd2;
  localparam logic [2:0] STG_TX_SYNC  = 3'd0;
  localparam logic [2:0] STG_TX_READY = 3'd1;
  localparam logic [2:0] STG_TX_TOKEN = 3'd2;
  localparam logic [2:0] STG_TX_DATA  = 3'd3;
  localparam logic [2:0] STG_TX_CRC   = 3'd4;
  localparam logic [2:0] STG_TX_RESP  = 3'd5;
  localparam logic [2:0] STG_TX_GAP   = 3'd6;
  localparam logic [2:0] STG_TX_BUSY  = 3'd7;

  // command start bytes
  localparam logic [7:0] CMD0   = 8'h40;
  localparam logic [7:0] CMD1   = 8'h41;
  localparam logic [7:0] CMD8   = 8'h48;
  localparam logic [7:0] CMD9   = 8'h49;
  localparam logic [7:0] CMD12  = 8'h4C;
  localparam logic [7:0] CMD16  = 8'h50;
  localparam logic [7:0] CMD17  = 8'h51;
  localparam logic [7:0] CMD18  = 8'h52;
  localparam logic [7:0] CMD24  = 8'h58;
  localparam logic [7:0] CMD25  = 8'h59;
  localparam logic [7:0] CMD55  = 8'h77;
  localparam logic [7:0] CMD58  = 8'h7A;
  localparam logic [7:0] ACMD23 = 8'hD7;
  localparam logic [7:0] ACMD41 = 8'hE9;

  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] CRC_OTHER  = 8'h01;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] TOK_SINGLE = 8'hFE;
  localparam logic [7:0] TOK_MULTI  = 8'hFC;
  localparam logic [7:0] TOK_STOP   = 8'hFD;
  localparam logic [4:0] RESP_MASK  = 5'h1F;
  localparam logic [4:0] RESP_OK    = 5'h05;

  localparam logic [4:0] LEAD_CMD   = 5'd15;
  localparam logic [4:0] LEAD_APP   = 5'd25;

  localparam logic [3:0] TYPE_MMC   = 4'h1;
  localparam logic [3:0] TYPE_SD1   = 4'h2;
  localparam logic [3:0] TYPE_SD2   = 4'h4;
  localparam logic [3:0] TYPE_SD2BA = 4'hC;
  localparam logic [3:0] TYPE_SDANY = 4'h6;

  // byte of a command frame
  function automatic logic [7:0] cmd_frame_byte(logic [2:0] stage, logic [CNT_W-1:0] cnt,
                                                logic [7:0] frame, logic [31:0] arg);
    logic [7:0] b;
    b = IDLE_BYTE;
    if (stage == STG_FRAME) begin
      if (cnt == '0) begin
        b = frame;
      end else if (cnt < CNT_W'(5)) begin
        unique case (cnt[2:0])
          3'd1:    b = arg[31:24];
          3'd2:    b = arg[23:16];
          3'd3:    b = arg[15:8];
          default: b = arg[7:0];
        endcase
      end else if (frame == CMD0) begin
        b = CRC_CMD0;
      end else if (frame == CMD8) begin
        b = CRC_CMD8;
      end else begin
        b = CRC_OTHER;
      end
    end
    return b;
  endfunction

  // capacity in blocks from the csd bytes
  function automatic logic [31:0] csd_sectors(logic [7:0] r0, logic [7:0] r5, logic [7:0] r6,
                                              logic [7:0] r7, logic [7:0] r8, logic [7:0] r9,
                                              logic [7:0] r10);
    logic [16:0] cs2;
    logic [4:0]  n;
    logic [12:0] cs1;
    logic [31:0] v;
    cs2 = {1'b0, r8, r9} + 17'd1;
    n   = 5'(r5[3:0]) + 5'(r10[7]) + 5'({r9[1:0], 1'b0}) + 5'd2;
    cs1 = 13'(r8[7:6]) + 13'({r7, 2'b00}) + 13'({r6[1:0], 10'd0}) + 13'd1;
    if (r0[7:6] == 2'd1) begin
      v = {5'd0, cs2, 10'd0};
    end else if (n < 5'd9) begin
      v = '0;
    end else begin
      v = 32'(cs1) << (n - 5'd9);
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/sd_card_spi_host_engine.sv
// sd_card_spi_host_engine: host side of sd/mmc spi mode, one step per transfer
// depends on sdspi_pkg (types, command codes, frame and csd helpers)
// the result of each input transfer is registered and appears in the next cycle
// throughput: one input transfer per cycle; the output register frees itself in
//   the cycle its result is taken, so in_ready stays high while out_ready is high
// reset (rst, synchronous): idle, card type 0, not initialised, response_tries 200
// the csd/ocr byte store is not cleared by reset
module sd_card_spi_host_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [2:0]  op,
  input  logic        drive_select,
  input  logic [31:0] sector,
  input  logic [7:0]  block_count,
  input  logic [7:0]  card_byte,
  input  logic [7:0]  write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  mosi_byte,
  output logic        exchange_wanted,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        write_byte_wanted,
  output logic        done_res,
  output logic [1:0]  result_code,
  output logic [3:0]  card_type,
  output logic        not_initialized,
  output logic [31:0] sector_count,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data
);
  import sdspi_pkg::*;

  // architectural state
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  byte_counter, byte_counter_next;
  logic [7:0]        poll_counter, poll_counter_next;
  logic [3:0]        card_type_reg, card_type_reg_next;
  logic              init_flag, init_flag_next;
  logic [31:0]       command_arg, command_arg_next;
  logic [7:0]        blocks_left, blocks_left_next;
  logic [7:0]        register_bytes [16];
  logic [7:0]        register_bytes_next [16];
  logic [7:0]        response_tries;

  // sequencer working state
  sub_t              sub, sub_next;
  await_t            awaiting, awaiting_next;
  logic [2:0]        stage, stage_next;
  logic [4:0]        lead_len, lead_len_next;
  logic [7:0]        cur_cmd, cur_cmd_next;
  logic              app_stage, app_stage_next;
  logic [7:0]        resp, resp_next;
  logic              sub_ok, sub_ok_next;
  logic              rx_host, rx_host_next;
  logic [7:0]        tx_token, tx_token_next;
  logic [3:0]        work_type, work_type_next;
  logic [7:0]        loop_cmd, loop_cmd_next;
  logic              code_hold, code_hold_next;
  logic [CNT_W-1:0]  rx_len, rx_len_next;
  logic [31:0]       block_addr, block_addr_next;
  logic [31:0]       cap_val, cap_val_next;

  // step results
  logic [7:0]        mosi_byte_next, read_byte_next;
  logic              exchange_wanted_next, read_valid_next, write_byte_wanted_next;
  logic              done_res_next;
  logic [1:0]        result_code_next;
  logic [31:0]       sector_count_next;

  // step scratch
  logic              step_en, run_go, sub_fin, emit_en, want_wr;
  logic [7:0]        emit_byte, cmd_frame;
  logic [31:0]       cmd_arg_eff;
  act_t              act;
  logic [CNT_W-1:0]  act_len;
  logic [7:0]        act_cmd;
  logic [31:0]       act_arg;
  logic              act_host;
  res_t              act_code;

  // the block takes a transfer whenever the result register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign step_en  = in_valid && in_ready;

  always_comb begin
    phase_next         = phase;
    byte_counter_next  = byte_counter;
    poll_counter_next  = poll_counter;
    card_type_reg_next = card_type_reg;
    init_flag_next     = init_flag;
    command_arg_next   = command_arg;
    blocks_left_next   = blocks_left;
    register_bytes_next = register_bytes;
    sub_next           = sub;
    awaiting_next      = awaiting;
    stage_next         = stage;
    lead_len_next      = lead_len;
    cur_cmd_next       = cur_cmd;
    app_stage_next     = app_stage;
    resp_next          = resp;
    sub_ok_next        = sub_ok;
    rx_host_next       = rx_host;
    tx_token_next      = tx_token;
    work_type_next     = work_type;
    loop_cmd_next      = loop_cmd;
    code_hold_next     = code_hold;
    rx_len_next        = rx_len;
    block_addr_next    = block_addr;
    cap_val_next       = cap_val;

    read_byte_next     = '0;
    read_valid_next    = 1'b0;
    sector_count_next  = '0;

    run_go    = 1'b0;
    sub_fin   = 1'b0;
    emit_en   = 1'b0;
    emit_byte = IDLE_BYTE;
    want_wr   = 1'b0;
    act       = ACT_NONE;
    act_len   = '0;
    act_cmd   = '0;
    act_arg   = '0;
    act_host  = 1'b0;
    act_code  = RES_OK;
    cmd_frame   = '0;
    cmd_arg_eff = '0;

    // ---- front end: request, card byte or write byte
    if (kind == KIND_REQUEST) begin
      if (phase == PH_IDLE) begin
        priority if (drive_select) begin
          act = ACT_FINISH; act_code = RES_PARAM;
        end else if (op == OP_INIT) begin
          phase_next = PH_INIT_START; run_go = 1'b1;
        end else if (op > OP_COUNT ||
                     ((op == OP_READ || op == OP_WRITE) && block_count == 8'd0)) begin
          act = ACT_FINISH; act_code = RES_PARAM;
        end else if (init_flag) begin
          act = ACT_FINISH; act_code = RES_NOT_READY;
        end else if (op == OP_TYPE) begin
          phase_next = PH_TYPE_START; run_go = 1'b1;
        end else if (op == OP_COUNT) begin
          phase_next = PH_CNT_START; run_go = 1'b1;
        end else begin
          blocks_left_next = block_count;
          // byte addressing scales the sector, wrapping at 32 bits
          block_addr_next  = card_type_reg[3] ? sector : {sector[22:0], 9'd0};
          phase_next = (op == OP_READ) ? PH_RD_START : PH_WR_START;
          run_go = 1'b1;
        end
      end
    end else if (kind == KIND_CARD && awaiting == AW_CARD) begin
      awaiting_next = AW_NONE;
      unique case (sub)
        SUB_DUMMY: begin
          byte_counter_next = byte_counter - CNT_W'(1);
          if (byte_counter_next == '0) sub_fin = 1'b1;
          else emit_en = 1'b1;
        end
        SUB_CMD: begin
          // command: idle lead-in, six frame bytes, optional stuff byte, then polling
          priority case (stage)
            STG_LEAD: begin
              byte_counter_next = byte_counter + CNT_W'(1);
              if (byte_counter_next >= CNT_W'(lead_len)) begin
                stage_next = STG_FRAME; byte_counter_next = '0;
              end
              emit_en = 1'b1;
            end
            STG_FRAME: begin
              byte_counter_next = byte_counter + CNT_W'(1);
              if (byte_counter_next >= CNT_W'(6)) begin
                if (!app_stage && cur_cmd[6:0] == CMD12[6:0]) begin
                  stage_next = STG_GAP;
                end else begin
                  stage_next = STG_TX_READY | STG_GAP; poll_counter_next = response_tries;
                end
              end
              emit_en = 1'b1;
            end
            STG_GAP: begin
              stage_next = STG_TX_READY | STG_GAP;
              poll_counter_next = response_tries;
              emit_en = 1'b1;
            end
            default: begin
              poll_counter_next = poll_counter - 8'd1;
              if (poll_counter_next == 8'd0 || !card_byte[7]) begin
                if (app_stage && card_byte <= 8'd1) begin
                  // cmd55 taken: now the application command itself
                  app_stage_next = 1'b0;
                  stage_next = STG_LEAD;
                  byte_counter_next = '0;
                  lead_len_next = LEAD_APP;
                  emit_en = 1'b1;
                end else begin
                  resp_next = card_byte; sub_fin = 1'b1;
                end
              end else begin
                emit_en = 1'b1;
              end
            end
          endcase
          cmd_frame   = app_stage_next ? CMD55 : {1'b0, cur_cmd[6:0]};
          cmd_arg_eff = app_stage_next ? 32'd0 : command_arg;
          emit_byte   = cmd_frame_byte(stage_next, byte_counter_next, cmd_frame, cmd_arg_eff);
        end
        SUB_RECV4: begin
          register_bytes_next[byte_counter[3:0]] = card_byte;
          byte_counter_next = byte_counter + CNT_W'(1);
          if (byte_counter_next >= CNT_W'(4)) sub_fin = 1'b1;
          else emit_en = 1'b1;
        end
        SUB_RX: begin
          priority case (stage)
            STG_RX_TOKEN: begin
              if (card_byte == IDLE_BYTE) begin
                emit_en = 1'b1;
              end else if (card_byte != TOK_SINGLE) begin
                sub_ok_next = 1'b0; sub_fin = 1'b1;
              end else begin
                stage_next = STG_RX_DATA; byte_counter_next = '0; emit_en = 1'b1;
              end
            end
            STG_RX_DATA: begin
              if (rx_host) begin
                read_byte_next = card_byte; read_valid_next = 1'b1;
              end else begin
                register_bytes_next[byte_counter[3:0]] = card_byte;
              end
              byte_counter_next = byte_counter + CNT_W'(1);
              if (byte_counter_next >= rx_len) begin
                stage_next = STG_RX_CRC; byte_counter_next = '0;
              end
              emit_en = 1'b1;
            end
            default: begin
              byte_counter_next = byte_counter + CNT_W'(1);
              if (byte_counter_next >= CNT_W'(2)) begin
                sub_ok_next = 1'b1; sub_fin = 1'b1;
              end else begin
                emit_en = 1'b1;
              end
            end
          endcase
        end
        SUB_TX: begin
          unique case (stage)
            STG_TX_SYNC: begin
              stage_next = STG_TX_READY; emit_en = 1'b1;
            end
            STG_TX_READY: begin
              if (card_byte == IDLE_BYTE) begin
                stage_next = STG_TX_TOKEN; emit_byte = tx_token;
              end
              emit_en = 1'b1;
            end
            STG_TX_TOKEN: begin
              if (tx_token == TOK_STOP) begin
                stage_next = STG_TX_GAP; emit_en = 1'b1;
              end else begin
                stage_next = STG_TX_DATA; byte_counter_next = '0; want_wr = 1'b1;
              end
            end
            STG_TX_DATA: begin
              byte_counter_next = byte_counter + CNT_W'(1);
              if (byte_counter_next >= CNT_W'(BLOCK_BYTES)) begin
                stage_next = STG_TX_CRC; byte_counter_next = '0; emit_en = 1'b1;
              end else begin
                want_wr = 1'b1;
              end
            end
            STG_TX_CRC: begin
              byte_counter_next = byte_counter + CNT_W'(1);
              if (byte_counter_next >= CNT_W'(2)) stage_next = STG_TX_RESP;
              emit_en = 1'b1;
            end
            STG_TX_RESP: begin
              if ((card_byte[4:0] & RESP_MASK) != RESP_OK) begin
                sub_ok_next = 1'b0; sub_fin = 1'b1;
              end else begin
                stage_next = STG_TX_GAP; emit_en = 1'b1;
              end
            end
            STG_TX_GAP: begin
              stage_next = STG_TX_BUSY; emit_en = 1'b1;
            end
            default: begin
              // busy: wait for the card to release the line
              if (card_byte == IDLE_BYTE) begin
                sub_ok_next = 1'b1; sub_fin = 1'b1;
              end else begin
                emit_en = 1'b1;
              end
            end
          endcase
        end
        default: sub_fin = 1'b1;
      endcase
      if (sub_fin) begin
        sub_next = SUB_NONE; run_go = 1'b1;
      end
    end else if (kind == KIND_WRITE && awaiting == AW_HOST) begin
      awaiting_next = AW_NONE;
      emit_en   = 1'b1;
      emit_byte = write_byte;
    end

    // ---- request sequencer; a phase may fall through once into the next
    for (int pass = 0; pass < 2; pass++) begin
      if (run_go) begin
        run_go = 1'b0;
        unique case (phase_next)
          PH_INIT_START: begin
            phase_next = PH_INIT_GO_IDLE; act = ACT_DUMMY; act_len = CNT_W'(100);
          end
          PH_INIT_GO_IDLE: begin
            phase_next = PH_INIT_GO_IDLE_RESP; act = ACT_CMD; act_cmd = CMD0;
          end
          PH_INIT_GO_IDLE_RESP: begin
            if (resp_next != 8'd1) begin
              act = ACT_FINISH; act_code = RES_ERROR;
            end else begin
              phase_next = PH_INIT_IF_COND; act = ACT_DUMMY; act_len = CNT_W'(80);
            end
          end
          PH_INIT_IF_COND: begin
            phase_next = PH_INIT_IF_COND_RESP; act = ACT_CMD; act_cmd = CMD8;
            act_arg = 32'h0000_01AA;
          end
          PH_INIT_IF_COND_RESP: begin
            if (resp_next == 8'd1) begin
              phase_next = PH_INIT_OCR_CHECK; act = ACT_RECV4;
            end else begin
              phase_next = PH_INIT_V1_PROBE; act = ACT_CMD; act_cmd = ACMD41;
            end
          end
          PH_INIT_OCR_CHECK: begin
            if (register_bytes_next[2] == 8'h01 && register_bytes_next[3] == 8'hAA) begin
              phase_next = PH_INIT_SD2_ACMD41; act = ACT_CMD; act_cmd = ACMD41;
              act_arg = 32'h4000_0000;
            end else begin
              work_type_next = '0; phase_next = PH_INIT_SET_TYPE; run_go = 1'b1;
            end
          end
          PH_INIT_SD2_ACMD41: begin
            if (resp_next != 8'd0) begin
              act = ACT_CMD; act_cmd = ACMD41; act_arg = 32'h4000_0000;
            end else begin
              phase_next = PH_INIT_SD2_PAUSE; act = ACT_DUMMY; act_len = CNT_W'(10);
            end
          end
          PH_INIT_SD2_PAUSE: begin
            phase_next = PH_INIT_SD2_CMD58; act = ACT_CMD; act_cmd = CMD58;
          end
          PH_INIT_SD2_CMD58: begin
            if (resp_next == 8'd0) begin
              phase_next = PH_INIT_SD2_CCS; act = ACT_RECV4;
            end else begin
              work_type_next = '0; phase_next = PH_INIT_SET_TYPE; run_go = 1'b1;
            end
          end
          PH_INIT_SD2_CCS: begin
            work_type_next = register_bytes_next[0][6] ? TYPE_SD2BA : TYPE_SD2;
            phase_next = PH_INIT_SET_TYPE; run_go = 1'b1;
          end
          PH_INIT_V1_PROBE: begin
            if (resp_next <= 8'd1) begin
              work_type_next = TYPE_SD1; loop_cmd_next = ACMD41;
            end else begin
              work_type_next = TYPE_MMC; loop_cmd_next = CMD1;
            end
            phase_next = PH_INIT_V1_PAUSE; act = ACT_DUMMY; act_len = CNT_W'(10);
          end
          PH_INIT_V1_PAUSE: begin
            phase_next = PH_INIT_V1_LOOP; act = ACT_CMD; act_cmd = loop_cmd_next;
          end
          PH_INIT_V1_LOOP: begin
            if (resp_next != 8'd0) begin
              act = ACT_CMD; act_cmd = loop_cmd_next;
            end else begin
              phase_next = PH_INIT_V1_PAUSE2; act = ACT_DUMMY; act_len = CNT_W'(10);
            end
          end
          PH_INIT_V1_PAUSE2: begin
            phase_next = PH_INIT_V1_BLKLEN; act = ACT_CMD; act_cmd = CMD16;
            act_arg = 32'(BLOCK_BYTES);
          end
          PH_INIT_V1_BLKLEN: begin
            if (resp_next != 8'd0) work_type_next = '0;
            phase_next = PH_INIT_SET_TYPE; run_go = 1'b1;
          end
          PH_INIT_SET_TYPE: begin
            card_type_reg_next = work_type_next;
            phase_next = PH_INIT_FINISH; act = ACT_DUMMY; act_len = CNT_W'(10);
          end
          PH_INIT_FINISH: begin
            init_flag_next = (card_type_reg_next == '0);
            act = ACT_FINISH;
            act_code = (card_type_reg_next != '0) ? RES_OK : RES_ERROR;
          end
          PH_RD_START: begin
            act = ACT_CMD; act_arg = block_addr_next;
            if (blocks_left_next == 8'd1) begin
              phase_next = PH_RD_SINGLE; act_cmd = CMD17;
            end else begin
              phase_next = PH_RD_MULTI; act_cmd = CMD18;
            end
          end
          PH_RD_SINGLE: begin
            if (resp_next == 8'd0) begin
              phase_next = PH_RD_SINGLE_DATA; act = ACT_RX;
              act_len = CNT_W'(BLOCK_BYTES); act_host = 1'b1;
            end else begin
              phase_next = PH_RD_CLOSE; run_go = 1'b1;
            end
          end
          PH_RD_SINGLE_DATA: begin
            if (sub_ok_next) blocks_left_next = '0;
            phase_next = PH_RD_CLOSE; run_go = 1'b1;
          end
          PH_RD_MULTI: begin
            if (resp_next == 8'd0) begin
              phase_next = PH_RD_MULTI_DATA; act = ACT_RX;
              act_len = CNT_W'(BLOCK_BYTES); act_host = 1'b1;
            end else begin
              phase_next = PH_RD_CLOSE; run_go = 1'b1;
            end
          end
          PH_RD_MULTI_DATA: begin
            if (sub_ok_next) blocks_left_next = blocks_left_next - 8'd1;
            if (sub_ok_next && blocks_left_next != 8'd0) begin
              act = ACT_RX; act_len = CNT_W'(BLOCK_BYTES); act_host = 1'b1;
            end else begin
              // stop transmission
              phase_next = PH_RD_CLOSE; act = ACT_CMD; act_cmd = CMD12;
            end
          end
          PH_RD_CLOSE: begin
            phase_next = PH_RD_FINISH; act = ACT_DUMMY; act_len = CNT_W'(10);
          end
          PH_RD_FINISH, PH_WR_FINISH: begin
            act = ACT_FINISH;
            act_code = (blocks_left_next != 8'd0) ? RES_ERROR : RES_OK;
          end
          PH_WR_START: begin
            if (blocks_left_next == 8'd1) begin
              phase_next = PH_WR_SINGLE; act = ACT_CMD; act_cmd = CMD24;
              act_arg = block_addr_next;
            end else if ((card_type_reg_next & TYPE_SDANY) != '0) begin
              // pre-erase count for sd cards
              phase_next = PH_WR_MULTI_CMD; act = ACT_CMD; act_cmd = ACMD23;
              act_arg = 32'(blocks_left_next);
            end else begin
              phase_next = PH_WR_MULTI_CMD; run_go = 1'b1;
            end
          end
          PH_WR_SINGLE: begin
            if (resp_next == 8'd0) begin
              phase_next = PH_WR_SINGLE_DATA; act = ACT_TX; act_cmd = TOK_SINGLE;
            end else begin
              phase_next = PH_WR_FINISH; run_go = 1'b1;
            end
          end
          PH_WR_SINGLE_DATA: begin
            if (sub_ok_next) blocks_left_next = '0;
            phase_next = PH_WR_FINISH; run_go = 1'b1;
          end
          PH_WR_MULTI_CMD: begin
            phase_next = PH_WR_MULTI; act = ACT_CMD; act_cmd = CMD25;
            act_arg = block_addr_next;
          end
          PH_WR_MULTI: begin
            if (resp_next == 8'd0) begin
              phase_next = PH_WR_MULTI_DATA; act = ACT_TX; act_cmd = TOK_MULTI;
            end else begin
              phase_next = PH_WR_FINISH; run_go = 1'b1;
            end
          end
          PH_WR_MULTI_DATA: begin
            if (sub_ok_next) blocks_left_next = blocks_left_next - 8'd1;
            if (sub_ok_next && blocks_left_next != 8'd0) begin
              act = ACT_TX; act_cmd = TOK_MULTI;
            end else begin
              phase_next = PH_WR_STOP; act = ACT_TX; act_cmd = TOK_STOP;
            end
          end
          PH_WR_STOP: begin
            if (!sub_ok_next) blocks_left_next = 8'd1;
            phase_next = PH_WR_FINISH; run_go = 1'b1;
          end
          PH_CNT_START: begin
            phase_next = PH_CNT_CSD; act = ACT_CMD; act_cmd = CMD9;
          end
          PH_CNT_CSD: begin
            if (resp_next == 8'd0) begin
              phase_next = PH_CNT_CSD_DATA; act = ACT_RX; act_len = CNT_W'(16);
            end else begin
              code_hold_next = 1'b1; phase_next = PH_CNT_CLOSE; run_go = 1'b1;
            end
          end
          PH_CNT_CSD_DATA: begin
            if (sub_ok_next) begin
              cap_val_next = csd_sectors(register_bytes_next[0], register_bytes_next[5],
                                         register_bytes_next[6], register_bytes_next[7],
                                         register_bytes_next[8], register_bytes_next[9],
                                         register_bytes_next[10]);
              code_hold_next = 1'b0;
            end else begin
              code_hold_next = 1'b1;
            end
            phase_next = PH_CNT_CLOSE; run_go = 1'b1;
          end
          PH_CNT_CLOSE: begin
            phase_next = PH_CNT_FINISH; act = ACT_DUMMY; act_len = CNT_W'(10);
          end
          PH_CNT_FINISH: begin
            if (!code_hold_next) sector_count_next = cap_val_next;
            act = ACT_FINISH; act_code = code_hold_next ? RES_ERROR : RES_OK;
          end
          PH_TYPE_START: begin
            phase_next = PH_TYPE_FINISH; act = ACT_DUMMY; act_len = CNT_W'(10);
          end
          PH_TYPE_FINISH: begin
            act = ACT_FINISH; act_code = RES_OK;
          end
          default: begin
            act = ACT_FINISH; act_code = RES_ERROR;
          end
        endcase
      end
    end

    // ---- launch the chosen sub-sequence
    done_res_next    = 1'b0;
    result_code_next = RES_OK;
    unique case (act)
      ACT_DUMMY: begin
        sub_next = SUB_DUMMY; byte_counter_next = act_len;
        emit_en = 1'b1; emit_byte = IDLE_BYTE;
      end
      ACT_CMD: begin
        sub_next = SUB_CMD; cur_cmd_next = act_cmd; command_arg_next = act_arg;
        app_stage_next = act_cmd[7]; stage_next = STG_LEAD; byte_counter_next = '0;
        lead_len_next = LEAD_CMD; emit_en = 1'b1; emit_byte = IDLE_BYTE;
      end
      ACT_RECV4: begin
        sub_next = SUB_RECV4; byte_counter_next = '0;
        emit_en = 1'b1; emit_byte = IDLE_BYTE;
      end
      ACT_RX: begin
        sub_next = SUB_RX; rx_len_next = act_len; rx_host_next = act_host;
        stage_next = STG_RX_TOKEN; emit_en = 1'b1; emit_byte = IDLE_BYTE;
      end
      ACT_TX: begin
        sub_next = SUB_TX; tx_token_next = act_cmd; stage_next = STG_TX_SYNC;
        emit_en = 1'b1; emit_byte = IDLE_BYTE;
      end
      ACT_FINISH: begin
        done_res_next = 1'b1; result_code_next = act_code;
        phase_next = PH_IDLE; sub_next = SUB_NONE;
      end
      default: ;
    endcase

    if (emit_en) awaiting_next = AW_CARD;
    if (want_wr) awaiting_next = AW_HOST;
    if (act == ACT_FINISH) awaiting_next = AW_NONE;

    mosi_byte_next         = emit_en ? emit_byte : IDLE_BYTE;
    exchange_wanted_next   = emit_en;
    write_byte_wanted_next = want_wr;
  end

  // state registers advance on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_counter  <= '0;
      poll_counter  <= '0;
      card_type_reg <= '0;
      init_flag     <= 1'b1;
      command_arg   <= '0;
      blocks_left   <= '0;
      sub           <= SUB_NONE;
      awaiting      <= AW_NONE;
      stage         <= STG_LEAD;
      lead_len      <= LEAD_CMD;
      app_stage     <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      byte_counter  <= byte_counter_next;
      poll_counter  <= poll_counter_next;
      card_type_reg <= card_type_reg_next;
      init_flag     <= init_flag_next;
      command_arg   <= command_arg_next;
      blocks_left   <= blocks_left_next;
      sub           <= sub_next;
      awaiting      <= awaiting_next;
      stage         <= stage_next;
      lead_len      <= lead_len_next;
      app_stage     <= app_stage_next;
    end
  end

  // working values that are always written before they are read
  always_ff @(posedge clk) begin
    if (step_en) begin
      register_bytes <= register_bytes_next;
      cur_cmd        <= cur_cmd_next;
      resp           <= resp_next;
      sub_ok         <= sub_ok_next;
      rx_host        <= rx_host_next;
      tx_token       <= tx_token_next;
      work_type      <= work_type_next;
      loop_cmd       <= loop_cmd_next;
      code_hold      <= code_hold_next;
      rx_len         <= rx_len_next;
      block_addr     <= block_addr_next;
      cap_val        <= cap_val_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      response_tries <= 8'd200;
    end else if (cfg_write_en) begin
      response_tries <= cfg_write_data;
    end
  end

  // result register: loaded on an input transfer, emptied by an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      mosi_byte         <= mosi_byte_next;
      exchange_wanted   <= exchange_wanted_next;
      read_byte         <= read_byte_next;
      read_valid        <= read_valid_next;
      write_byte_wanted <= write_byte_wanted_next;
      done_res          <= done_res_next;
      result_code       <= result_code_next;
      card_type         <= card_type_reg_next;
      not_initialized   <= init_flag_next;
      sector_count      <= sector_count_next;
    end
  end

endmodule
